// File: sv/wtsp_pkg.sv
package wtsp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE_I = 1 << FRAC_BITS;
  localparam int THRESH_I = (ONE_I + 9) / 10;
  localparam logic signed [31:0] ONE = 32'(ONE_I);
  localparam logic signed [31:0] THRESH = 32'(THRESH_I);

  localparam int DIV_W = 32 + FRAC_BITS;
  localparam int SUM_W = 66;
  localparam int SCR_W = 14;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_COMMIT = 2'd1;
  localparam logic [1:0] OP_PROJECT = 2'd2;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [SCR_W-1:0] WIDTH_RESET = SCR_W'(1920);
  localparam logic [SCR_W-1:0] HEIGHT_RESET = SCR_W'(1080);

  typedef struct packed {
    logic [1:0]         op;
    logic               sel;
    logic [3:0]         idx;
    logic signed [31:0] value;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } item_t;

  typedef struct packed {
    logic               vis;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] w;
  } clip_t;

  typedef struct packed {
    logic                  vis;
    logic signed [DIV_W:0] nx;
    logic signed [DIV_W:0] ny;
  } ndc_t;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > SUM_W'(32'sh7fffffff)) begin
      r = 32'sh7fffffff;
    end else if (v < -SUM_W'(33'sh080000000)) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: sv/world_to_screen_projection.sv
// Projects world points to screen pixels through a view and a projection
// matrix, both loaded one element per item. Load, commit and project items
// share one in-order pipeline, so a load takes effect exactly for the
// items that follow it. One item is accepted per cycle while the result
// side keeps up; a project item passes four matrix stages (multiply and
// sum for each matrix), a 48-stage restoring divider that yields one
// quotient bit per stage, and two screen mapping stages. A stalled result
// holds the whole pipeline, and the input queue then fills its two entries
// before it stops accepting. The screen size registers take effect for
// results produced after the write.
module world_to_screen_projection (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic                          matrix_select,
  input  logic [3:0]                    element_index,
  input  logic signed [31:0]            element_value,
  input  logic signed [31:0]            point_x,
  input  logic signed [31:0]            point_y,
  input  logic signed [31:0]            point_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          visible,
  output logic signed [31:0]            screen_x,
  output logic signed [31:0]            screen_y,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [wtsp_pkg::SCR_W-1:0]    cfg_data
);
  import wtsp_pkg::*;

  item_t              in_item;
  item_t              head;
  logic               head_valid;
  logic               pop;
  logic               en;
  logic               clip_valid;
  clip_t              clip;
  logic               ndc_valid;
  ndc_t               ndc;
  logic [SCR_W-1:0]   scr_width;
  logic [SCR_W-1:0]   scr_height;
  logic               mv;
  logic               mvis;
  logic signed [63:0] prodx;
  logic signed [63:0] prody;
  logic signed [63:0] wq;
  logic signed [63:0] hq;
  logic signed [63:0] sx;
  logic signed [63:0] sy;

  assign in_item.op = opcode;
  assign in_item.sel = matrix_select;
  assign in_item.idx = element_index;
  assign in_item.value = element_value;
  assign in_item.x = point_x;
  assign in_item.y = point_y;
  assign in_item.z = point_z;

  assign en = !out_valid || out_ready;

  wtsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  wtsp_xform u_xform (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .clip_valid(clip_valid),
    .clip      (clip)
  );

  wtsp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .clip_valid(clip_valid),
    .clip      (clip),
    .ndc_valid (ndc_valid),
    .ndc       (ndc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_width <= WIDTH_RESET;
      scr_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WIDTH:  scr_width <= cfg_data;
        CFG_HEIGHT: scr_height <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign wq = $signed(64'(scr_width)) <<< FRAC_BITS;
  assign hq = $signed(64'(scr_height)) <<< FRAC_BITS;
  assign sx = (wq + prodx) >>> 1;
  assign sy = (hq - prody) >>> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      mvis <= ndc.vis;
      prodx <= ndc.nx * $signed({1'b0, scr_width});
      prody <= ndc.ny * $signed({1'b0, scr_height});
      visible <= mvis;
      screen_x <= mvis ? sat32(SUM_W'(sx)) : '0;
      screen_y <= mvis ? sat32(SUM_W'(sy)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mv <= ndc_valid;
      out_valid <= mv;
    end
  end

endmodule

// File: sv/wtsp_front.sv
module wtsp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  wtsp_pkg::item_t in_item,
  output logic            head_valid,
  output wtsp_pkg::item_t head,
  input  logic            pop
);
  import wtsp_pkg::*;

  item_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       keep;
  logic       push;

  assign keep = in_item.op == OP_LOAD || in_item.op == OP_COMMIT ||
                in_item.op == OP_PROJECT;
  assign in_ready = count != 2'd2;
  assign push = in_valid && in_ready && keep;
  assign head_valid = count != 2'd0;
  assign head = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: sv/wtsp_xform.sv
module wtsp_xform (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            head_valid,
  input  wtsp_pkg::item_t head,
  output logic            pop,
  output logic            clip_valid,
  output wtsp_pkg::clip_t clip
);
  import wtsp_pkg::*;

  logic signed [31:0] view_m [16];
  logic signed [31:0] proj_m [16];
  logic               mvalid;
  logic signed [31:0] pv [4];

  logic               v0;
  item_t              it0;
  logic signed [63:0] prod0 [16];

  logic               v1;
  item_t              it1;
  logic signed [31:0] vp [4];

  logic               v2;
  logic [1:0]         op2;
  logic signed [63:0] prod2 [16];

  logic signed [31:0] vp_next [4];
  logic signed [31:0] cp_next [4];

  assign pop = en && head_valid;
  assign pv[0] = head.x;
  assign pv[1] = head.y;
  assign pv[2] = head.z;
  assign pv[3] = ONE;

  always_comb begin
    logic signed [SUM_W-1:0] acc;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) begin
        acc = acc + SUM_W'(prod0[r*4+c] >>> FRAC_BITS);
      end
      vp_next[r] = sat32(acc);
    end
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) begin
        acc = acc + SUM_W'(prod2[r*4+c] >>> FRAC_BITS);
      end
      cp_next[r] = sat32(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it0 <= head;
      for (int k = 0; k < 16; k++) begin
        prod0[k] <= view_m[k] * pv[k % 4];
      end
      it1 <= it0;
      for (int r = 0; r < 4; r++) begin
        vp[r] <= vp_next[r];
      end
      op2 <= it1.op;
      for (int k = 0; k < 16; k++) begin
        prod2[k] <= proj_m[k] * vp[k % 4];
      end
      clip.vis <= mvalid && (cp_next[3] >= THRESH);
      clip.cx <= cp_next[0];
      clip.cy <= cp_next[1];
      clip.w <= cp_next[3];
      if (head_valid && head.op == OP_LOAD && !head.sel) begin
        view_m[head.idx] <= head.value;
      end
      if (v1 && it1.op == OP_LOAD && it1.sel) begin
        proj_m[it1.idx] <= it1.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      clip_valid <= 1'b0;
      mvalid <= 1'b0;
    end else if (en) begin
      v0 <= head_valid;
      v1 <= v0;
      v2 <= v1;
      clip_valid <= v2 && op2 == OP_PROJECT;
      if (v2 && op2 == OP_COMMIT) begin
        mvalid <= 1'b1;
      end
    end
  end

endmodule

// File: sv/wtsp_div.sv
module wtsp_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            clip_valid,
  input  wtsp_pkg::clip_t clip,
  output logic            ndc_valid,
  output wtsp_pkg::ndc_t  ndc
);
  import wtsp_pkg::*;

  typedef struct packed {
    logic [DIV_W-1:0] dvd;
    logic [31:0]      rem;
    logic [DIV_W-1:0] quot;
    logic             neg;
  } lane_t;

  typedef struct packed {
    lane_t       lx;
    lane_t       ly;
    logic [30:0] d;
    logic        vis;
  } stage_t;

  function automatic lane_t lane_init(input logic signed [31:0] c);
    lane_t       l;
    logic [32:0] t;
    t = c[31] ? -{c[31], c} : {c[31], c};
    l.dvd = {t[31:0], {FRAC_BITS{1'b0}}};
    l.rem = '0;
    l.quot = '0;
    l.neg = c[31];
    return l;
  endfunction

  function automatic lane_t lane_step(input lane_t l, input logic [30:0] d);
    lane_t       o;
    logic [31:0] sh;
    sh = {l.rem[30:0], l.dvd[DIV_W-1]};
    o = l;
    o.dvd = {l.dvd[DIV_W-2:0], 1'b0};
    if (sh >= {1'b0, d}) begin
      o.rem = sh - {1'b0, d};
      o.quot = {l.quot[DIV_W-2:0], 1'b1};
    end else begin
      o.rem = sh;
      o.quot = {l.quot[DIV_W-2:0], 1'b0};
    end
    return o;
  endfunction

  stage_t           st_in;
  stage_t           st [DIV_W];
  logic [DIV_W-1:0] vld;
  stage_t           last;

  assign st_in.lx = lane_init(clip.cx);
  assign st_in.ly = lane_init(clip.cy);
  assign st_in.d = clip.w[30:0];
  assign st_in.vis = clip.vis;

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    stage_t prev;
    logic   prev_v;
    if (k == 0) begin : g_first
      assign prev = st_in;
      assign prev_v = clip_valid;
    end else begin : g_next
      assign prev = st[k-1];
      assign prev_v = vld[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[k].lx <= lane_step(prev.lx, prev.d);
        st[k].ly <= lane_step(prev.ly, prev.d);
        st[k].d <= prev.d;
        st[k].vis <= prev.vis;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= prev_v;
      end
    end
  end

  assign last = st[DIV_W-1];
  assign ndc_valid = vld[DIV_W-1];
  assign ndc.vis = last.vis;
  assign ndc.nx = last.lx.neg ? -$signed({1'b0, last.lx.quot}) : $signed({1'b0, last.lx.quot});
  assign ndc.ny = last.ly.neg ? -$signed({1'b0, last.ly.quot}) : $signed({1'b0, last.ly.quot});

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import wtsp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [1:0]         op;
    logic               sel;
    logic [3:0]         idx;
    logic signed [31:0] value;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cmd_t;

  typedef struct {
    logic               vis;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = '0;
  logic matrix_select = 1'b0;
  logic [3:0] element_index = '0;
  logic signed [31:0] element_value = '0;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic signed [31:0] point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic visible;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [SCR_W-1:0] cfg_data = '0;

  cmd_t cmd_q[$];
  pixel_t pixel_q[$];
  cmd_t cur;
  logic signed [31:0] view_m[16];
  logic signed [31:0] proj_m[16];
  logic committed = 1'b0;
  logic [SCR_W-1:0] scr_w = WIDTH_RESET;
  logic [SCR_W-1:0] scr_h = HEIGHT_RESET;
  int cycles = 0;
  int errors = 0;
  int results = 0;
  bit in_taken = 0;
  bit out_taken = 0;
  bit no_idle = 0;
  bit hold_done = 0;
  int in_gap = 0;
  int out_stall = 0;
  int hold_left = 0;

  world_to_screen_projection i_dut (.*);

  always #4 clk = ~clk;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic pixel_t project_point(cmd_t c);
    longint p[4], vp[4], cp[4];
    longint acc, nx, ny, wd, ht;
    pixel_t r;
    p[0] = longint'(c.x);
    p[1] = longint'(c.y);
    p[2] = longint'(c.z);
    p[3] = ONE_I;
    for (int row = 0; row < 4; row++) begin
      acc = 0;
      for (int col = 0; col < 4; col++)
        acc += (longint'(view_m[row*4+col]) * p[col]) >>> FRAC_BITS;
      vp[row] = clamp32(acc);
    end
    for (int row = 0; row < 4; row++) begin
      acc = 0;
      for (int col = 0; col < 4; col++)
        acc += (longint'(proj_m[row*4+col]) * vp[col]) >>> FRAC_BITS;
      cp[row] = clamp32(acc);
    end
    r = '{1'b0, 32'sd0, 32'sd0};
    if (committed && cp[3] >= THRESH_I) begin
      wd = scr_w;
      ht = scr_h;
      nx = (cp[0] * ONE_I) / cp[3];
      ny = (cp[1] * ONE_I) / cp[3];
      r.vis = 1'b1;
      r.sx = 32'(clamp32((wd * ONE_I + nx * wd) >>> 1));
      r.sy = 32'(clamp32((ht * ONE_I - ny * ht) >>> 1));
    end
    return r;
  endfunction

  function automatic void apply_item(cmd_t c);
    case (c.op)
      OP_LOAD: begin
        if (c.sel) proj_m[c.idx] = c.value;
        else view_m[c.idx] = c.value;
      end
      OP_COMMIT: committed = 1'b1;
      OP_PROJECT: pixel_q.push_back(project_point(c));
      default: ;
    endcase
  endfunction

  function automatic cmd_t blank_cmd(logic [1:0] op);
    cmd_t c;
    c.op = op;
    c.sel = 1'($urandom);
    c.idx = 4'($urandom);
    c.value = $urandom;
    c.x = $urandom;
    c.y = $urandom;
    c.z = $urandom;
    return c;
  endfunction

  function automatic void push_load(logic sel, int idx, logic signed [31:0] v);
    cmd_t c;
    c = blank_cmd(OP_LOAD);
    c.sel = sel;
    c.idx = 4'(idx);
    c.value = v;
    cmd_q.push_back(c);
  endfunction

  function automatic void push_point(logic signed [31:0] x, logic signed [31:0] y,
                                     logic signed [31:0] z);
    cmd_t c;
    c = blank_cmd(OP_PROJECT);
    c.x = x;
    c.y = y;
    c.z = z;
    cmd_q.push_back(c);
  endfunction

  function automatic logic signed [31:0] near_one(int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic signed [31:0] tame_value(logic sel, int idx);
    if (sel && idx == 14) return 32'(ONE_I) + near_one(ONE_I / 2);
    if (sel && idx == 15) return near_one(ONE_I);
    if (!sel && idx == 15) return 32'(ONE_I);
    return near_one(ONE_I);
  endfunction

  function automatic void push_tame_matrices();
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < 16; i++)
        push_load(1'(s), i, tame_value(1'(s), i));
  endfunction

  function automatic void push_random_item();
    int pick;
    logic sel;
    int idx;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      push_point(near_one(8 * ONE_I), near_one(8 * ONE_I),
                 32'($urandom_range(0, 10 * ONE_I)));
    end else if (pick < 80) begin
      cmd_q.push_back(blank_cmd(OP_PROJECT));
    end else if (pick < 90) begin
      sel = 1'($urandom);
      idx = $urandom_range(0, 15);
      push_load(sel, idx, tame_value(sel, idx));
    end else if (pick < 94) begin
      cmd_q.push_back(blank_cmd(OP_LOAD));
    end else if (pick < 97) begin
      cmd_q.push_back(blank_cmd(OP_COMMIT));
    end else begin
      cmd_q.push_back(blank_cmd(OP_UNUSED));
    end
  endfunction

  task automatic wait_idle();
    while (cmd_q.size() > 0 || in_valid || pixel_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_screen(logic [SCR_W-1:0] wd, logic [SCR_W-1:0] ht);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data <= wd;
    @(negedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data <= ht;
    @(negedge clk);
    cfg_write <= 1'b0;
    scr_w = wd;
    scr_h = ht;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && in_valid && in_ready) begin
      apply_item(cur);
      in_taken = 1;
    end
  end

  always @(negedge clk) begin
    logic nxt;
    nxt = in_valid;
    if (!rst) begin
      if (in_taken) begin
        in_taken = 0;
        nxt = 1'b0;
        in_gap = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (!nxt && cmd_q.size() > 0) begin
        if (in_gap > 0) begin
          in_gap--;
        end else begin
          cur = cmd_q.pop_front();
          opcode <= cur.op;
          matrix_select <= cur.sel;
          element_index <= cur.idx;
          element_value <= cur.value;
          point_x <= cur.x;
          point_y <= cur.y;
          point_z <= cur.z;
          nxt = 1'b1;
        end
      end
    end
    in_valid <= nxt;
  end

  always @(posedge clk) begin
    pixel_t exp_px;
    if (!rst && out_valid && out_ready) begin
      out_taken = 1;
      results++;
      if (pixel_q.size() == 0) begin
        $error("unexpected result: visible=%0d x=%0d y=%0d", visible, screen_x, screen_y);
        errors++;
      end else begin
        exp_px = pixel_q.pop_front();
        if (visible !== exp_px.vis) begin
          $error("visible: expected %0d, got %0d", exp_px.vis, visible);
          errors++;
        end
        if (screen_x !== exp_px.sx) begin
          $error("screen_x: expected %0d, got %0d", exp_px.sx, screen_x);
          errors++;
        end
        if (screen_y !== exp_px.sy) begin
          $error("screen_y: expected %0d, got %0d", exp_px.sy, screen_y);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) begin
        out_taken = 0;
        out_stall = no_idle ? 0 : $urandom_range(0, 6);
        if (!hold_done && results >= 150 && cmd_q.size() > 10) begin
          hold_done = 1;
          hold_left = 300;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    logic [SCR_W-1:0] sizes[6][2];
    sizes = '{'{WIDTH_RESET, HEIGHT_RESET}, '{14'd1, 14'd1}, '{14'd8192, 14'd8192},
              '{14'd0, 14'd0}, '{14'd16383, 14'd16383}, '{14'd640, 14'd8191}};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity view; projection passes x, y and puts z into w
    for (int i = 0; i < 16; i++) begin
      push_load(1'b0, i, (i % 5 == 0) ? 32'(ONE_I) : 32'sd0);
      push_load(1'b1, i, (i == 0 || i == 5 || i == 14) ? 32'(ONE_I) : 32'sd0);
    end
    push_point(32'(ONE_I), 32'(ONE_I), 32'(ONE_I));
    cmd_q.push_back(blank_cmd(OP_UNUSED));
    cmd_q.push_back(blank_cmd(OP_COMMIT));
    push_point(32'(ONE_I), -32'(ONE_I), 32'(ONE_I));
    push_point(32'sd0, 32'sd0, 32'sd0);
    push_point(32'sd0, 32'sd0, 32'(THRESH_I - 1));
    push_point(32'sd0, 32'sd0, 32'(THRESH_I));
    push_point(32'sh7fffffff, 32'sh80000000, 32'(THRESH_I));
    push_point(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    push_point(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    push_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    push_point(-32'sd1, -32'sd1, -32'sd1);
    push_load(1'b1, 15, 32'sh80000000);
    push_point(32'(ONE_I), 32'(ONE_I), 32'sh7fffffff);
    push_load(1'b1, 15, 32'sh7fffffff);
    push_point(32'(ONE_I), 32'(ONE_I), 32'(ONE_I));
    cmd_q.push_back(blank_cmd(OP_COMMIT));

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      if (ph > 0)
        write_screen(ph < 6 ? sizes[ph][0] : 14'($urandom_range(1, 8192)),
                     ph < 6 ? sizes[ph][1] : 14'($urandom_range(1, 8192)));
      no_idle = (ph % 3 == 2);
      push_tame_matrices();
      for (int n = 0; n < 68; n++) push_random_item();
    end

    wait_idle();
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
